>>> rtl/core/gauss_seidel_solver_defines.svh
// assertion macros shared by the solver rtl
// expects signals named clk and rst_n in the including module
`ifndef GAUSS_SEIDEL_SOLVER_DEFINES_SVH
`define GAUSS_SEIDEL_SOLVER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define GSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/gss_pkg.sv
// shared types, constants and helpers for the gauss-seidel solver
// no dependencies
`timescale 1ns / 1ps

package gss_pkg;

  localparam int DATA_W   = 48;
  localparam int ERR_W    = 56;
  localparam int TOL_W    = 47;
  localparam int NV_W     = 4;
  localparam int ITER_W   = 8;
  localparam int VIDX_W   = 3;
  localparam int CFG_W    = 47;
  localparam int HALF_W   = 24;
  localparam int MAX_VARS = 8;

  localparam logic [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [NV_W-1:0]   NUM_VARS_RST = 4'd3;
  localparam logic [TOL_W-1:0]  TOL_RST      = 47'd4295;
  localparam logic [ITER_W-1:0] MAX_ITER_RST = 8'd30;

  typedef enum logic [1:0] {
    CFG_NUM_VARS  = 2'd0,
    CFG_TOLERANCE = 2'd1,
    CFG_MAX_ITER  = 2'd2
  } cfg_idx_t;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_ROW   = 14'b00000000000010,
    S_JSEL  = 14'b00000000000100,
    S_MWAIT = 14'b00000000001000,
    S_MUL   = 14'b00000000010000,
    S_ACC   = 14'b00000000100000,
    S_BWAIT = 14'b00000001000000,
    S_DWAIT = 14'b00000010000000,
    S_DIV   = 14'b00000100000000,
    S_WB    = 14'b00001000000000,
    S_SWEEP = 14'b00010000000000,
    S_ORD   = 14'b00100000000000,
    S_OWAIT = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic rd_mat;
    logic rd_sol;
    logic clr_sum;
    logic mul_start;
    logic acc;
    logic num;
    logic div_start;
    logic wb;
    logic clr_err;
    logic out_cap;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic err_lt_tol;
  } status_t;

  // sign and magnitude back to a saturated two's complement value
  function automatic logic [DATA_W-1:0] from_mag(input logic neg, input logic big,
                                                 input logic [DATA_W-2:0] m);
    logic [DATA_W-1:0] r;
    if (!neg) begin
      r = big ? VMAX : {1'b0, m};
    end else begin
      r = big ? VMIN : (~{1'b0, m} + 1'b1);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/gss_if.sv
// valid/ready channel interfaces for the solver input and result streams
// depends on gss_pkg
`timescale 1ns / 1ps

interface gss_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [gss_pkg::DATA_W-1:0]   coefficient;
  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface

interface gss_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [gss_pkg::DATA_W-1:0]   solution_value;
  logic [gss_pkg::VIDX_W-1:0]          var_index;
  logic                                converged;
  logic [gss_pkg::ITER_W-1:0]          iterations_used;
  logic                                divide_error;
  logic                                last_result;
  modport source (output valid, output solution_value, output var_index, output converged,
                  output iterations_used, output divide_error, output last_result,
                  input ready);
  modport sink   (input valid, input solution_value, input var_index, input converged,
                  input iterations_used, input divide_error, input last_result,
                  output ready);
endinterface

>>> rtl/core/gss_mul.sv
// sequential fixed point multiplier: four 24x24 partial products, truncated and saturated
// depends on gss_pkg
`timescale 1ns / 1ps

module gss_mul #(
  parameter int FRAC_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gss_pkg::DATA_W-1:0]    a,
  input  logic [gss_pkg::DATA_W-1:0]    b,
  output logic                          done,
  output logic [gss_pkg::DATA_W-1:0]    prod
);

  localparam int DW = gss_pkg::DATA_W;
  localparam int HW = gss_pkg::HALF_W;
  localparam int PW = 2 * DW;

  logic [DW-1:0]   amag_r, bmag_r;
  logic            neg_r;
  logic [PW-1:0]   acc_r, acc_nxt;
  logic [1:0]      cnt_r;
  logic            busy_r, done_r;
  logic [HW-1:0]   ah, bh;
  logic [2*HW-1:0] pp;
  logic [PW-1:0]   pp_ext;
  logic            big;

  assign ah = cnt_r[0] ? amag_r[DW-1:HW] : amag_r[HW-1:0];
  assign bh = cnt_r[1] ? bmag_r[DW-1:HW] : bmag_r[HW-1:0];
  assign pp = ah * bh;

  always_comb begin
    pp_ext = {{(PW-2*HW){1'b0}}, pp};
    case ({cnt_r[1], cnt_r[0]})
      2'b00:   acc_nxt = acc_r + pp_ext;
      2'b11:   acc_nxt = acc_r + (pp_ext << (2*HW));
      default: acc_nxt = acc_r + (pp_ext << HW);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 2'd3);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      amag_r <= a[DW-1] ? (~a + 1'b1) : a;
      bmag_r <= b[DW-1] ? (~b + 1'b1) : b;
      neg_r  <= a[DW-1] ^ b[DW-1];
      acc_r  <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign big  = |acc_r[PW-1:FRAC_BITS+DW-1];
  assign prod = gss_pkg::from_mag(neg_r, big, acc_r[FRAC_BITS+DW-2:FRAC_BITS]);
  assign done = done_r;

endmodule

>>> rtl/core/gss_div.sv
// radix-2 restoring divider for (num << FRAC_BITS) / den, one quotient bit a cycle
// depends on gss_pkg
`timescale 1ns / 1ps

module gss_div #(
  parameter int FRAC_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gss_pkg::DATA_W-1:0]    num,
  input  logic [gss_pkg::DATA_W-1:0]    den,
  output logic                          done,
  output logic [gss_pkg::DATA_W-1:0]    quot
);

  localparam int DW  = gss_pkg::DATA_W;
  localparam int NB  = DW + FRAC_BITS;
  localparam int CNW = $clog2(NB + 1);

  logic [NB-1:0]  dv_r;
  logic [DW-1:0]  d_r, r_r, q_r;
  logic [DW:0]    r2;
  logic           ge;
  logic           neg_r, ovf_r, zero_r, nz_r, nneg_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r, done_r;
  logic [DW-1:0]  nmag, dmag;

  assign nmag = num[DW-1] ? (~num + 1'b1) : num;
  assign dmag = den[DW-1] ? (~den + 1'b1) : den;
  assign r2   = {r_r, dv_r[NB-1]};
  assign ge   = r2 >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= (dmag != '0);
        done_r <= (dmag == '0);
        cnt_r  <= CNW'(NB - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv_r   <= {nmag, {FRAC_BITS{1'b0}}};
      d_r    <= dmag;
      r_r    <= '0;
      q_r    <= '0;
      ovf_r  <= 1'b0;
      neg_r  <= num[DW-1] ^ den[DW-1];
      zero_r <= (dmag == '0);
      nz_r   <= (num != '0);
      nneg_r <= num[DW-1];
    end else if (busy_r) begin
      dv_r  <= {dv_r[NB-2:0], 1'b0};
      r_r   <= ge ? DW'(r2 - {1'b0, d_r}) : r2[DW-1:0];
      q_r   <= {q_r[DW-2:0], ge};
      ovf_r <= ovf_r | q_r[DW-1];
    end
  end

  // zero divisor saturates by the sign of the numerator
  assign quot = zero_r ? gss_pkg::from_mag(nneg_r, nz_r, '0)
                       : gss_pkg::from_mag(neg_r, ovf_r | q_r[DW-1], q_r[DW-2:0]);
  assign done = done_r;

endmodule

>>> rtl/core/gss_datapath.sv
// solver datapath: matrix and solution stores, sum, numerator, error accumulator
// depends on gss_pkg, gss_mul, gss_div
`timescale 1ns / 1ps

module gss_datapath #(
  parameter int MAX_VARS  = 8,
  parameter int FRAC_BITS = 32,
  parameter int AW        = 7,
  parameter int IW        = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gss_pkg::cmd_t                 cmd,
  input  logic [AW-1:0]                 mat_waddr,
  input  logic [AW-1:0]                 mat_addr,
  input  logic [IW-1:0]                 sol_addr,
  input  logic [gss_pkg::DATA_W-1:0]    coefficient,
  input  logic [gss_pkg::TOL_W-1:0]     tolerance,
  output gss_pkg::status_t              status,
  output logic [gss_pkg::DATA_W-1:0]    sol_out,
  output logic                          dz
);

  localparam int DW = gss_pkg::DATA_W;
  localparam int EW = gss_pkg::ERR_W;
  localparam int MD = MAX_VARS * (MAX_VARS + 1);

  logic [DW-1:0]       mat_mem [MD];
  logic [DW-1:0]       sol_mem [MAX_VARS];
  logic [MAX_VARS-1:0] sol_vld_r;
  logic [DW-1:0]       mat_q_r, sol_q_r, sol_rd;
  logic                sol_qv_r;
  logic [DW-1:0]       sum_r, num_r, old_r, out_val_r;
  logic [EW-1:0]       err_r;
  logic                dz_r;
  logic [DW-1:0]       prod, quot;
  logic                mul_done, div_done;
  logic [DW:0]         diff, dmag;
  logic [EW:0]         err_sum;

  function automatic logic [DW-1:0] sat50(input logic [DW+1:0] x);
    logic [DW-1:0] r;
    if (!x[DW+1] && (x[DW:DW-1] != 2'b00)) r = gss_pkg::VMAX;
    else if (x[DW+1] && (x[DW:DW-1] != 2'b11)) r = gss_pkg::VMIN;
    else r = x[DW-1:0];
    return r;
  endfunction

  gss_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.mul_start),
    .a(mat_q_r), .b(sol_rd), .done(mul_done), .prod(prod)
  );

  gss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(num_r), .den(mat_q_r), .done(div_done), .quot(quot)
  );

  // entries not yet written this solve read as zero
  assign sol_rd = sol_qv_r ? sol_q_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) mat_mem[mat_waddr] <= coefficient;
    if (cmd.rd_mat) mat_q_r <= mat_mem[mat_addr];
    if (cmd.wb) sol_mem[sol_addr] <= quot;
    if (cmd.rd_sol) begin
      sol_q_r  <= sol_mem[sol_addr];
      sol_qv_r <= sol_vld_r[sol_addr];
    end
  end

  assign diff    = {quot[DW-1], quot} - {old_r[DW-1], old_r};
  assign dmag    = diff[DW] ? (~diff + 1'b1) : diff;
  assign err_sum = {1'b0, err_r} + (EW+1)'(dmag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sol_vld_r <= '0;
      err_r     <= '0;
      dz_r      <= 1'b0;
    end else begin
      if (cmd.start) begin
        sol_vld_r <= '0;
        err_r     <= '0;
        dz_r      <= 1'b0;
      end else begin
        if (cmd.clr_err) err_r <= '0;
        if (cmd.div_start && (mat_q_r == '0)) dz_r <= 1'b1;
        if (cmd.wb) begin
          sol_vld_r[sol_addr] <= 1'b1;
          err_r <= err_sum[EW] ? {EW{1'b1}} : err_sum[EW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_sum) sum_r <= '0;
    else if (cmd.acc) sum_r <= sat50({{2{sum_r[DW-1]}}, sum_r} + {{2{prod[DW-1]}}, prod});
    if (cmd.num) num_r <= sat50({{2{mat_q_r[DW-1]}}, mat_q_r} - {{2{sum_r[DW-1]}}, sum_r});
    if (cmd.div_start) old_r <= sol_rd;
    if (cmd.out_cap) out_val_r <= sol_rd;
  end

  assign status.mul_done   = mul_done;
  assign status.div_done   = div_done;
  assign status.err_lt_tol = err_r < EW'(tolerance);
  assign sol_out           = out_val_r;
  assign dz                = dz_r;

endmodule

>>> rtl/core/gss_ctrl.sv
// solver sequencer: load counting, row and sweep iteration, result emission
// depends on gss_pkg and gauss_seidel_solver_defines.svh
`timescale 1ns / 1ps
`include "gauss_seidel_solver_defines.svh"

module gss_ctrl #(
  parameter int MAX_VARS = 8,
  parameter int AW       = 7,
  parameter int IW       = 3,
  parameter int CW       = 4,
  parameter int LW       = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gss_pkg::NV_W-1:0]      num_vars,
  input  logic [gss_pkg::ITER_W-1:0]    max_iterations,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  gss_pkg::status_t              status,
  output gss_pkg::cmd_t                 cmd,
  output logic [AW-1:0]                 mat_waddr,
  output logic [AW-1:0]                 mat_addr,
  output logic [IW-1:0]                 sol_addr,
  output logic [CW-1:0]                 k_idx,
  output logic                          last,
  output logic                          conv,
  output logic [gss_pkg::ITER_W-1:0]    sweeps
);

  localparam int MD = MAX_VARS * (MAX_VARS + 1);

  gss_pkg::state_t          state_r, state_nxt;
  logic [CW-1:0]            i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [AW-1:0]            base_r, base_nxt;
  logic [LW-1:0]            load_r, load_nxt, load_inc, total;
  logic [gss_pkg::ITER_W-1:0] sweep_r, sweep_nxt, limit;
  logic                     conv_r, conv_nxt;
  logic [CW-1:0]            n_eff;

  always_comb begin
    if (num_vars == '0) n_eff = CW'(1);
    else if (32'(num_vars) > MAX_VARS) n_eff = CW'(MAX_VARS);
    else n_eff = CW'(num_vars);
  end

  assign limit    = (max_iterations == '0) ? gss_pkg::ITER_W'(1) : max_iterations;
  assign total    = LW'(LW'(n_eff) * (LW'(n_eff) + LW'(1)));
  assign load_inc = load_r + LW'(1);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    base_nxt  = base_r;
    load_nxt  = load_r;
    sweep_nxt = sweep_r;
    conv_nxt  = conv_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    mat_addr  = base_r + AW'(j_r);
    sol_addr  = j_r[IW-1:0];
    unique case (state_r)
      gss_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = (load_r < LW'(MD));
          load_nxt = load_inc;
          if (load_inc >= total) begin
            load_nxt  = '0;
            cmd.start = 1'b1;
            sweep_nxt = '0;
            conv_nxt  = 1'b0;
            i_nxt     = '0;
            base_nxt  = '0;
            state_nxt = gss_pkg::S_ROW;
          end
        end
      end
      gss_pkg::S_ROW: begin
        cmd.clr_sum = 1'b1;
        j_nxt       = '0;
        state_nxt   = gss_pkg::S_JSEL;
      end
      gss_pkg::S_JSEL: begin
        if (j_r == n_eff) begin
          // right-hand side of the row
          mat_addr   = base_r + AW'(n_eff);
          cmd.rd_mat = 1'b1;
          state_nxt  = gss_pkg::S_BWAIT;
        end else if (j_r == i_r) begin
          j_nxt = j_r + CW'(1);
        end else begin
          cmd.rd_mat = 1'b1;
          cmd.rd_sol = 1'b1;
          state_nxt  = gss_pkg::S_MWAIT;
        end
      end
      gss_pkg::S_MWAIT: begin
        cmd.mul_start = 1'b1;
        state_nxt     = gss_pkg::S_MUL;
      end
      gss_pkg::S_MUL: begin
        if (status.mul_done) state_nxt = gss_pkg::S_ACC;
      end
      gss_pkg::S_ACC: begin
        cmd.acc   = 1'b1;
        j_nxt     = j_r + CW'(1);
        state_nxt = gss_pkg::S_JSEL;
      end
      gss_pkg::S_BWAIT: begin
        cmd.num    = 1'b1;
        mat_addr   = base_r + AW'(i_r);
        sol_addr   = i_r[IW-1:0];
        cmd.rd_mat = 1'b1;
        cmd.rd_sol = 1'b1;
        state_nxt  = gss_pkg::S_DWAIT;
      end
      gss_pkg::S_DWAIT: begin
        cmd.div_start = 1'b1;
        state_nxt     = gss_pkg::S_DIV;
      end
      gss_pkg::S_DIV: begin
        if (status.div_done) state_nxt = gss_pkg::S_WB;
      end
      gss_pkg::S_WB: begin
        sol_addr = i_r[IW-1:0];
        cmd.wb   = 1'b1;
        i_nxt    = i_r + CW'(1);
        base_nxt = base_r + AW'(n_eff) + AW'(1);
        if (i_r + CW'(1) == n_eff) state_nxt = gss_pkg::S_SWEEP;
        else state_nxt = gss_pkg::S_ROW;
      end
      gss_pkg::S_SWEEP: begin
        sweep_nxt = sweep_r + gss_pkg::ITER_W'(1);
        k_nxt     = '0;
        if (status.err_lt_tol) begin
          conv_nxt  = 1'b1;
          state_nxt = gss_pkg::S_ORD;
        end else if (sweep_r + gss_pkg::ITER_W'(1) == limit) begin
          state_nxt = gss_pkg::S_ORD;
        end else begin
          cmd.clr_err = 1'b1;
          i_nxt       = '0;
          base_nxt    = '0;
          state_nxt   = gss_pkg::S_ROW;
        end
      end
      gss_pkg::S_ORD: begin
        sol_addr   = k_r[IW-1:0];
        cmd.rd_sol = 1'b1;
        state_nxt  = gss_pkg::S_OWAIT;
      end
      gss_pkg::S_OWAIT: begin
        cmd.out_cap = 1'b1;
        state_nxt   = gss_pkg::S_OUT;
      end
      gss_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (k_r + CW'(1) == n_eff) begin
            state_nxt = gss_pkg::S_IDLE;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = gss_pkg::S_ORD;
          end
        end
      end
      default: state_nxt = gss_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gss_pkg::S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      base_r  <= '0;
      load_r  <= '0;
      sweep_r <= '0;
      conv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      base_r  <= base_nxt;
      load_r  <= load_nxt;
      sweep_r <= sweep_nxt;
      conv_r  <= conv_nxt;
    end
  end

  assign mat_waddr = load_r[AW-1:0];
  assign k_idx     = k_r;
  assign last      = (k_r + CW'(1) == n_eff);
  assign conv      = conv_r;
  assign sweeps    = sweep_r;

  `GSS_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input taken while a result is pending")
  `GSS_ASSERT_NEXT(a_conv_set, (state_r == gss_pkg::S_SWEEP) && status.err_lt_tol, conv_r,
                   "converged flag not set after small sweep error")
  `GSS_ASSERT_NOW(a_row_range, (state_r == gss_pkg::S_DIV), i_r < n_eff,
                  "row index beyond system size")
  `GSS_ASSERT_NOW(a_out_range, out_valid, (k_r < n_eff) && (sweep_r != '0),
                  "result index out of range or no sweep done")

endmodule

>>> rtl/core/gauss_seidel_solver.sv
// channel        dir   payload
// in_chan        in    coefficient (signed q16.32, row-major augmented matrix)
// out_chan       out   solution_value, var_index, converged, iterations_used,
//                      divide_error, last_result
// cfg_*          in    num_vars, tolerance, max_iterations (write only)
//
// one coefficient per cycle while loading; the last one of the matrix starts the solve.
// each off-diagonal product of a row runs on the shared 24x24 multiplier in four passes;
// a row then takes set-up, right-hand side and a bit-serial divide (no divide steps run
// when the diagonal is zero); a sweep is n rows plus the S_SWEEP check.
// results leave one at a time, held by output stalls; no input is taken meanwhile.
// reset is synchronous, active low; the matrix store needs no clearing.
// top level of the gauss-seidel solver; depends on gss_pkg, gss_if, gss_ctrl, gss_datapath
`timescale 1ns / 1ps

module gauss_seidel_solver #(
  parameter int FRAC_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  gss_in_if.sink                     in_chan,
  gss_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [gss_pkg::CFG_W-1:0]  cfg_data
);

  localparam int MAX_VARS = gss_pkg::MAX_VARS;
  localparam int MD  = MAX_VARS * (MAX_VARS + 1);
  localparam int AW  = (MD > 1) ? $clog2(MD) : 1;
  localparam int IW  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int CW  = $clog2(MAX_VARS + 1);
  localparam int LW  = ($clog2(MD + 1) > 7) ? $clog2(MD + 1) : 7;

  logic [gss_pkg::NV_W-1:0]   num_vars_r;
  logic [gss_pkg::TOL_W-1:0]  tol_r;
  logic [gss_pkg::ITER_W-1:0] max_iter_r;

  gss_pkg::cmd_t    cmd;
  gss_pkg::status_t status;
  logic [AW-1:0]    mat_waddr, mat_addr;
  logic [IW-1:0]    sol_addr;
  logic [CW-1:0]    k_idx;
  logic             last, conv, dz;
  logic [gss_pkg::ITER_W-1:0] sweeps;
  logic [gss_pkg::DATA_W-1:0] sol_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= gss_pkg::NUM_VARS_RST;
      tol_r      <= gss_pkg::TOL_RST;
      max_iter_r <= gss_pkg::MAX_ITER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gss_pkg::CFG_NUM_VARS:  num_vars_r <= cfg_data[gss_pkg::NV_W-1:0];
        gss_pkg::CFG_TOLERANCE: tol_r      <= cfg_data[gss_pkg::TOL_W-1:0];
        gss_pkg::CFG_MAX_ITER:  max_iter_r <= cfg_data[gss_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  gss_ctrl #(.MAX_VARS(MAX_VARS), .AW(AW), .IW(IW), .CW(CW), .LW(LW)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .num_vars(num_vars_r), .max_iterations(max_iter_r),
    .in_valid(in_chan.valid), .in_ready(in_chan.ready),
    .out_valid(out_chan.valid), .out_ready(out_chan.ready),
    .status(status), .cmd(cmd),
    .mat_waddr(mat_waddr), .mat_addr(mat_addr), .sol_addr(sol_addr),
    .k_idx(k_idx), .last(last), .conv(conv), .sweeps(sweeps)
  );

  gss_datapath #(.MAX_VARS(MAX_VARS), .FRAC_BITS(FRAC_BITS), .AW(AW), .IW(IW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .mat_waddr(mat_waddr), .mat_addr(mat_addr), .sol_addr(sol_addr),
    .coefficient(in_chan.coefficient), .tolerance(tol_r),
    .status(status), .sol_out(sol_out), .dz(dz)
  );

  assign out_chan.solution_value  = sol_out;
  assign out_chan.var_index       = gss_pkg::VIDX_W'(k_idx);
  assign out_chan.converged       = conv;
  assign out_chan.iterations_used = sweeps;
  assign out_chan.divide_error    = dz;
  assign out_chan.last_result     = last;

endmodule

>>> verif/tb.sv
// self-checking testbench for gauss_seidel_solver: directed table then random systems
// depends on rtl gss_pkg, gss_if and the solver top level
`timescale 1ns / 1ps

module tb;

  typedef logic signed [gss_pkg::DATA_W-1:0] val_t;

  typedef struct {
    val_t        value;
    logic [2:0]  idx;
    logic        conv;
    logic [7:0]  iters;
    logic        dz;
    logic        last;
  } solution_t;

  typedef struct {
    bit                is_cfg;
    gss_pkg::cfg_idx_t reg_idx;
    logic [46:0]       reg_data;
    val_t              coef;
    bit                typed;
    val_t              t_value;
    bit                t_conv;
    logic [7:0]        t_iters;
    bit                t_dz;
  } stim_row_t;

  localparam val_t ONE       = 48'sh1_0000_0000;
  localparam val_t POS_SAT   = val_t'(gss_pkg::VMAX);
  localparam val_t NEG_SAT   = val_t'(gss_pkg::VMIN);
  localparam int   IDLE_LIMIT = 1_500_000;
  localparam int   ITEM_GOAL  = 280;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [gss_pkg::CFG_W-1:0] cfg_data = '0;

  gss_in_if  in_if ();
  gss_out_if out_if ();

  gauss_seidel_solver dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if.sink), .out_chan(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  val_t        mat_copy [72];
  val_t        sol_copy [8];
  int          load_cnt;
  logic [3:0]  nv_reg;
  logic [46:0] tol_reg;
  logic [7:0]  iter_reg;

  solution_t   solutions_due [$];
  stim_row_t   stim_rows [$];
  int          fail_cnt = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  bit          quiet = 0;

  function automatic logic [127:0] mag48(val_t v);
    return v < 0 ? 128'(-longint'(v)) : 128'(v);
  endfunction

  function automatic val_t from_magnitude(bit neg, logic [127:0] m);
    if (!neg) return (m > 128'h7FFF_FFFF_FFFF) ? POS_SAT : val_t'(m[47:0]);
    return (m >= 128'h8000_0000_0000) ? NEG_SAT : val_t'(0) - val_t'(m[47:0]);
  endfunction

  function automatic val_t sat48(longint s);
    if (s > longint'(POS_SAT)) return POS_SAT;
    if (s < longint'(NEG_SAT)) return NEG_SAT;
    return val_t'(s);
  endfunction

  function automatic val_t fx_product(val_t a, val_t b);
    logic [127:0] p;
    p = mag48(a) * mag48(b);
    return from_magnitude((a < 0) != (b < 0), p >> 32);
  endfunction

  function automatic val_t fx_quotient(val_t num, val_t den, inout bit dz);
    logic [127:0] q;
    if (den == 0) begin
      dz = 1;
      return num > 0 ? POS_SAT : (num < 0 ? NEG_SAT : val_t'(0));
    end
    q = (mag48(num) << 32) / mag48(den);
    return from_magnitude((num < 0) != (den < 0), q);
  endfunction

  function automatic int eff_vars(logic [3:0] raw);
    return raw < 1 ? 1 : (raw > 8 ? 8 : int'(raw));
  endfunction

  // takes one accepted coefficient, returns the solution vector it completes (if any)
  function automatic int solve_step(val_t c, ref solution_t res [8]);
    int n, lim, sweeps, row;
    bit dz, conv;
    val_t prev [8];
    val_t sum;
    longint unsigned err;
    longint d;
    n = eff_vars(nv_reg);
    lim = iter_reg < 1 ? 1 : int'(iter_reg);
    dz = 0;
    conv = 0;
    if (load_cnt < 72) mat_copy[load_cnt] = c;
    load_cnt = (load_cnt + 1) & 127;
    if (load_cnt < n * (n + 1)) return 0;
    load_cnt = 0;
    foreach (sol_copy[i]) sol_copy[i] = 0;
    sweeps = 0;
    while (sweeps < lim) begin
      prev = sol_copy;
      for (int i = 0; i < n; i++) begin
        row = i * (n + 1);
        sum = 0;
        for (int j = 0; j < n; j++)
          if (j != i) sum = sat48(longint'(sum) + longint'(fx_product(mat_copy[row + j],
                                                                      sol_copy[j])));
        sol_copy[i] = fx_quotient(sat48(longint'(mat_copy[row + n]) - longint'(sum)),
                                  mat_copy[row + i], dz);
      end
      err = 0;
      for (int i = 0; i < n; i++) begin
        // full-width difference, it can exceed the 48-bit range
        d = longint'(sol_copy[i]) - longint'(prev[i]);
        err += 64'(d < 0 ? -d : d);
        if (err > 64'hFF_FFFF_FFFF_FFFF) err = 64'hFF_FFFF_FFFF_FFFF;
      end
      sweeps++;
      if (err < 64'(tol_reg)) begin
        conv = 1;
        break;
      end
    end
    for (int k = 0; k < n; k++)
      res[k] = '{sol_copy[k], 3'(k), conv, 8'(sweeps), dz, k == n - 1};
    return n;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (solutions_due.size() != 0) @(posedge clk);
    // a transaction that completes nothing may still be settling in the block
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(gss_pkg::cfg_idx_t idx, logic [46:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      gss_pkg::CFG_NUM_VARS:  nv_reg = d[3:0];
      gss_pkg::CFG_TOLERANCE: tol_reg = d;
      gss_pkg::CFG_MAX_ITER:  iter_reg = d[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_coef(val_t c, bit typed, solution_t typed_res);
    solution_t res [8];
    int cnt;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.coefficient <= c;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    cnt = solve_step(c, res);
    if (cnt > 0 && typed) solutions_due.push_back(typed_res);
    else for (int k = 0; k < cnt; k++) solutions_due.push_back(res[k]);
  endtask

  function automatic void row_cfg(gss_pkg::cfg_idx_t idx, logic [46:0] d);
    stim_rows.push_back('{1, idx, d, 0, 0, 0, 0, 0, 0});
  endfunction

  function automatic void row_coef(val_t c);
    stim_rows.push_back('{0, gss_pkg::CFG_NUM_VARS, 0, c, 0, 0, 0, 0, 0});
  endfunction

  // single-variable system with a result that can be read off directly
  function automatic void row_typed(val_t c, val_t v, bit conv, logic [7:0] it, bit dz);
    stim_rows.push_back('{0, gss_pkg::CFG_NUM_VARS, 0, c, 1, v, conv, it, dz});
  endfunction

  function automatic val_t rand_full();
    return val_t'({$urandom, $urandom});
  endfunction

  task automatic send_system(int n, bit noisy);
    solution_t none;
    val_t c;
    none = '{0, 0, 0, 0, 0, 0};
    for (int i = 0; i < n; i++)
      for (int j = 0; j <= n; j++) begin
        if (noisy) c = rand_full();
        else if (j == i) begin
          c = val_t'((longint'(n + 1 + $urandom_range(0, 3)) <<< 32) + $urandom);
          if ($urandom_range(0, 1)) c = -c;
          if ($urandom_range(0, 19) == 0) c = 0;
        end else if (j == n) c = val_t'((longint'($urandom) - 64'sd2147483648) <<< 4);
        else c = val_t'((longint'($urandom) - 64'sd2147483648) <<< 1);
        if (items_sent >= ITEM_GOAL - 40) quiet = 1;
        send_coef(c, 0, none);
      end
  endtask

  // result side: random stalls plus one long hold-off
  int  hold_cnt = 0;
  int  stall_cnt = 0;
  bit  hold_done = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (!hold_done && results_seen >= 10) begin
      hold_done = 1;
      hold_cnt = 400;
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_cnt = $urandom_range(0, 2);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    solution_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (solutions_due.size() == 0) begin
        $error("unexpected result transaction, var_index %0d", out_if.var_index);
        fail_cnt++;
      end else begin
        e = solutions_due.pop_front();
        if (out_if.solution_value !== e.value) begin
          $error("solution_value: expected %0d, got %0d", e.value, out_if.solution_value);
          fail_cnt++;
        end
        if (out_if.var_index !== e.idx) begin
          $error("var_index: expected %0d, got %0d", e.idx, out_if.var_index);
          fail_cnt++;
        end
        if (out_if.converged !== e.conv) begin
          $error("converged: expected %0d, got %0d", e.conv, out_if.converged);
          fail_cnt++;
        end
        if (out_if.iterations_used !== e.iters) begin
          $error("iterations_used: expected %0d, got %0d", e.iters, out_if.iterations_used);
          fail_cnt++;
        end
        if (out_if.divide_error !== e.dz) begin
          $error("divide_error: expected %0d, got %0d", e.dz, out_if.divide_error);
          fail_cnt++;
        end
        if (out_if.last_result !== e.last) begin
          $error("last_result: expected %0d, got %0d", e.last, out_if.last_result);
          fail_cnt++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    solution_t tr;
    int n_raw, n, nsys;
    bit noisy;
    logic [46:0] tol;
    logic [7:0] mi;
    in_if.valid = 1'b0;
    in_if.coefficient = '0;
    load_cnt = 0;
    nv_reg = gss_pkg::NUM_VARS_RST;
    tol_reg = gss_pkg::TOL_RST;
    iter_reg = gss_pkg::MAX_ITER_RST;
    foreach (mat_copy[i]) mat_copy[i] = 0;
    foreach (sol_copy[i]) sol_copy[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    row_cfg(gss_pkg::CFG_NUM_VARS, 1);
    row_coef(0);                                    // zero diagonal, positive rhs
    row_typed(5 * ONE, POS_SAT, 1, 2, 1);
    row_coef(0);                                    // zero diagonal, negative rhs
    row_typed(-ONE, NEG_SAT, 1, 2, 1);
    row_coef(0);                                    // zero diagonal, zero rhs
    row_typed(0, 0, 1, 1, 1);
    row_coef(2 * ONE);
    row_typed(6 * ONE, 3 * ONE, 1, 2, 0);
    row_coef(POS_SAT);
    row_coef(NEG_SAT);
    row_coef(NEG_SAT);
    row_coef(POS_SAT);
    row_cfg(gss_pkg::CFG_MAX_ITER, 0);              // acts as one sweep
    row_coef(ONE);
    row_typed(ONE, ONE, 0, 1, 0);
    row_cfg(gss_pkg::CFG_TOLERANCE, 0);             // never converges
    row_cfg(gss_pkg::CFG_MAX_ITER, 255);
    row_coef(ONE);
    row_typed(ONE, ONE, 0, 255, 0);
    row_cfg(gss_pkg::CFG_NUM_VARS, 0);              // acts as one unknown
    row_cfg(gss_pkg::CFG_TOLERANCE, 47'h7FFF_FFFF_FFFF);
    row_cfg(gss_pkg::CFG_MAX_ITER, 3);
    row_coef(ONE);
    row_typed(2 * ONE, 2 * ONE, 1, 1, 0);
    // size change while loading: load continues, solve starts at the new size
    row_cfg(gss_pkg::CFG_NUM_VARS, 2);
    row_cfg(gss_pkg::CFG_TOLERANCE, 4295);
    row_cfg(gss_pkg::CFG_MAX_ITER, 30);
    row_coef(3 * ONE);
    row_coef(ONE + 12345);
    row_coef(-ONE);
    row_cfg(gss_pkg::CFG_NUM_VARS, 1);
    row_coef(7 * ONE);

    tr = '{0, 0, 0, 0, 0, 0};
    foreach (stim_rows[r]) begin
      if (stim_rows[r].is_cfg) begin
        wait_idle();
        write_reg(stim_rows[r].reg_idx, stim_rows[r].reg_data);
      end else begin
        tr = '{stim_rows[r].t_value, 0, stim_rows[r].t_conv, stim_rows[r].t_iters,
               stim_rows[r].t_dz, 1};
        send_coef(stim_rows[r].coef, stim_rows[r].typed, tr);
      end
    end

    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 19))
        0:       n_raw = 0;
        1:       n_raw = $urandom_range(9, 15);
        2, 3:    n_raw = 8;
        default: n_raw = $urandom_range(1, 4);
      endcase
      n = eff_vars(4'(n_raw));
      noisy = $urandom_range(0, 5) == 0;
      case ($urandom_range(0, 5))
        0:       tol = 0;
        1:       tol = 47'h7FFF_FFFF_FFFF;
        2:       tol = 47'({$urandom, $urandom});
        3:       tol = $urandom_range(0, 100000);
        default: tol = 4295;
      endcase
      if (noisy || tol == 0) mi = $urandom_range(0, 6);
      else if (n <= 2 && $urandom_range(0, 3) == 0) mi = 255;
      else mi = $urandom_range(5, 40);
      wait_idle();
      write_reg(gss_pkg::CFG_NUM_VARS, 47'(n_raw));
      write_reg(gss_pkg::CFG_TOLERANCE, tol);
      write_reg(gss_pkg::CFG_MAX_ITER, 47'(mi));
      nsys = $urandom_range(1, 2);
      for (int s = 0; s < nsys; s++) send_system(n, noisy);
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (solutions_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/gss_pkg.sv
rtl/core/gss_if.sv
rtl/core/gss_mul.sv
rtl/core/gss_div.sv
rtl/core/gss_datapath.sv
rtl/core/gss_ctrl.sv
rtl/core/gauss_seidel_solver.sv
verif/tb.sv
